FILE: rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants of the segment linear resampler.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int VALUE_W         = 24;
    localparam int CFG_W           = 7;
    localparam int MAX_POINTS_DEF  = 64;
    localparam int FRAC_BITS_DEF   = 8;
    localparam logic [CFG_W-1:0] TARGET_RESET = 7'd50;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    segment_end;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_point;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BASE_GO,
        ST_BASE_WAIT,
        ST_RD_PRE,
        ST_GET_PRE,
        ST_RD_CUR,
        ST_GET_CUR,
        ST_DIV_WAIT,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/slr_sample_mem.sv
// ----------------------------------------------------------------------------
// slr_sample_mem
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slr_sample_mem
    import slr_pkg::*;
#(
    parameter int DEPTH  = MAX_POINTS_DEF + 1,
    parameter int ADDR_W = $clog2(MAX_POINTS_DEF + 1)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_sample           i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_sample           o_rd_data
);

    t_sample r_mem [DEPTH];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/slr_divider.sv
// ----------------------------------------------------------------------------
// slr_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slr_divider
    import slr_pkg::*;
#(
    parameter int DIVIDEND_W = SAMPLE_W + FRAC_BITS_DEF,
    parameter int DIVISOR_W  = $clog2(MAX_POINTS_DEF + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_active;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVIDEND_W-1:0] n_quo;
    logic [DIVISOR_W-1:0]  n_rem;
    logic [DIVISOR_W:0]    rem_sh;

    // The partial remainder stays below the divisor, so one extra bit holds
    // the shifted value.
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
        if (rem_sh >= {1'b0, r_div}) begin
            n_rem = DIVISOR_W'(rem_sh - {1'b0, r_div});
            n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= CNT_W'(DIVIDEND_W);
            end else if (r_active) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_active) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/segment_linear_resampler.sv
// ----------------------------------------------------------------------------
// segment_linear_resampler
// Loading: one sample per cycle while busy is low.
// A single-sample segment reads its sample and goes straight to emitting
// its points. Otherwise the run first splits its points over the segments on
// the serial divider and reads the first sample; each segment then reads its
// end sample, divides its slope serially and emits its points, each point
// registered before it is strobed. The receiver cannot stall.
// Reset: length register 50, sample count zero; the store is not cleared.
// ----------------------------------------------------------------------------
module segment_linear_resampler
    import slr_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Sample requests.
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    // Result strobe and payload.
    output logic             o_result_valid,
    output t_out_item        o_result,
    // Length register write channel.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Store depth, index and count widths. A segment never has more than
    // MAX_POINTS sub-segments, so one index width serves addresses, segment
    // numbers and point counts alike.
    localparam int DEPTH = MAX_POINTS + 1;
    localparam int IW    = $clog2(MAX_POINTS + 1);
    localparam int CW    = $clog2(MAX_POINTS + 2);
    // Slope magnitude width, signed numerator width and accumulator width.
    localparam int DW    = SAMPLE_W + FRAC_BITS;
    localparam int NW    = DW + 1;
    localparam int AW    = DW + 2;
    localparam int XW    = (AW > VALUE_W) ? AW : VALUE_W;
    localparam logic signed [XW-1:0] VAL_MAX = XW'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] VAL_MIN = -VAL_MAX - XW'(1);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_target;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_len, n_len;
    logic [IW-1:0]        r_segs, n_segs;
    logic [IW-1:0]        r_base, n_base;
    logic [IW-1:0]        r_extra, n_extra;
    logic [IW-1:0]        r_j, n_j;
    logic [IW-1:0]        r_pts, n_pts;
    logic [IW-1:0]        r_k_left, n_k_left;
    logic                 r_single, n_single;
    logic                 r_neg, n_neg;
    t_sample              r_pre, n_pre;
    t_sample              r_cur, n_cur;
    logic signed [DW:0]   r_diff, n_diff;
    logic signed [AW-1:0] r_acc, n_acc;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 accept;
    logic                 wr_en;
    logic [CW-1:0]        count_new;
    logic [IW-1:0]        len_cap;
    logic [CW-1:0]        len_plus;
    logic [CW-1:0]        n_samples;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    t_sample              rd_data;
    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [IW-1:0]        div_divisor;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic [IW-1:0]        div_rem;
    logic [IW-1:0]        seg_pts;
    logic signed [NW-1:0] numer;
    logic signed [XW-1:0] acc_x;
    logic signed [VALUE_W-1:0] sat_value;
    logic                 last_pt;

    // The block takes samples only while it is not resampling.
    assign busy        = (r_state != ST_LOAD);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Samples beyond the store depth can never reach the result, so they are
    // dropped and the count saturates.
    assign wr_en     = accept && (r_count < CW'(DEPTH));
    assign count_new = wr_en ? (r_count + CW'(1)) : r_count;

    // Points per run, limited to MAX_POINTS; only the first len+1 samples
    // take part in the interpolation.
    assign len_cap   = (int'(r_target) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(r_target);
    assign len_plus  = CW'(len_cap) + CW'(1);
    assign n_samples = (count_new > len_plus) ? len_plus : count_new;

    // The first extra segments each get one point more than the base share.
    assign seg_pts = r_base + IW'(r_j <= r_extra);

    // Scaled rise from the previous sample to the one just read.
    assign numer = (NW'(rd_data) - NW'(r_pre)) <<< FRAC_BITS;

    slr_sample_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (i_item.sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // One serial divider serves both the point split of the run and the
    // slope of each segment; the two uses never overlap.
    slr_divider #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (IW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Sequencer: next state, memory reads, divider requests and datapath.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_len        = r_len;
        n_segs       = r_segs;
        n_base       = r_base;
        n_extra      = r_extra;
        n_j          = r_j;
        n_pts        = r_pts;
        n_k_left     = r_k_left;
        n_single     = r_single;
        n_neg        = r_neg;
        n_pre        = r_pre;
        n_cur        = r_cur;
        n_diff       = r_diff;
        n_acc        = r_acc;
        rd_en        = 1'b0;
        rd_addr      = '0;
        div_start    = 1'b0;
        div_dividend = DW'(r_len);
        div_divisor  = r_segs;

        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    n_count = count_new;
                    if (i_item.segment_end) begin
                        // The run is closed here whatever its length.
                        n_count  = '0;
                        n_len    = len_cap;
                        n_j      = IW'(1);
                        n_single = (n_samples == CW'(1));
                        if (n_samples == CW'(1)) begin
                            n_segs = IW'(1);
                        end else begin
                            n_segs = IW'(n_samples - CW'(1));
                        end
                        if (len_cap == '0) begin
                            n_state = ST_LOAD;
                        end else if (n_samples == CW'(1)) begin
                            n_state = ST_RD_PRE;
                        end else begin
                            n_state = ST_BASE_GO;
                        end
                    end
                end
            end
            ST_BASE_GO: begin
                div_start = 1'b1;
                n_state   = ST_BASE_WAIT;
            end
            ST_BASE_WAIT: begin
                if (div_done) begin
                    n_base  = div_quo[IW-1:0];
                    n_extra = div_rem;
                    n_state = ST_RD_PRE;
                end
            end
            ST_RD_PRE: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = ST_GET_PRE;
            end
            ST_GET_PRE: begin
                n_pre = rd_data;
                if (r_single) begin
                    // A lone sample is one flat segment over the whole run.
                    n_acc    = AW'(rd_data) <<< FRAC_BITS;
                    n_diff   = '0;
                    n_k_left = r_len;
                    n_state  = ST_EMIT;
                end else begin
                    n_state = ST_RD_CUR;
                end
            end
            ST_RD_CUR: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
                n_state = ST_GET_CUR;
            end
            ST_GET_CUR: begin
                n_cur        = rd_data;
                n_neg        = numer[NW-1];
                n_pts        = seg_pts;
                div_start    = 1'b1;
                div_dividend = numer[NW-1] ? DW'(-numer) : DW'(numer);
                div_divisor  = seg_pts;
                n_state      = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    // Dividing the magnitude and restoring the sign truncates
                    // toward zero.
                    if (r_neg) begin
                        n_diff = -$signed({1'b0, div_quo});
                    end else begin
                        n_diff = $signed({1'b0, div_quo});
                    end
                    n_acc    = AW'(r_pre) <<< FRAC_BITS;
                    n_k_left = r_pts;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_acc    = r_acc + AW'(r_diff);
                n_k_left = r_k_left - IW'(1);
                if (r_k_left == IW'(1)) begin
                    if (r_j == r_segs) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_pre   = r_cur;
                        n_j     = r_j + IW'(1);
                        n_state = ST_RD_CUR;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Clamp the accumulated point to the signed output range.
    always_comb begin
        acc_x = XW'(r_acc);
        if (acc_x > VAL_MAX) begin
            sat_value = VAL_MAX[VALUE_W-1:0];
        end else if (acc_x < VAL_MIN) begin
            sat_value = VAL_MIN[VALUE_W-1:0];
        end else begin
            sat_value = acc_x[VALUE_W-1:0];
        end
    end

    assign last_pt = (r_j == r_segs) && (r_k_left == IW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_target    <= TARGET_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= (r_state == ST_EMIT);
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len            <= n_len;
        r_segs           <= n_segs;
        r_base           <= n_base;
        r_extra          <= n_extra;
        r_j              <= n_j;
        r_pts            <= n_pts;
        r_k_left         <= n_k_left;
        r_single         <= n_single;
        r_neg            <= n_neg;
        r_pre            <= n_pre;
        r_cur            <= n_cur;
        r_diff           <= n_diff;
        r_acc            <= n_acc;
        r_out.value      <= sat_value;
        r_out.last_point <= last_pt;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the segment linear resampler. Segments of signed
// samples are fed through the start/busy port, and the length register is
// rewritten between segments. A scoreboard predicts every interpolated point
// and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import slr_pkg::*;

    localparam int     STORE_DEPTH   = MAX_POINTS_DEF + 1;
    localparam longint SCALE         = longint'(1) << FRAC_BITS_DEF;
    localparam longint VALUE_HI      = (longint'(1) << (VALUE_W - 1)) - 1;
    localparam longint VALUE_LO      = -(longint'(1) << (VALUE_W - 1));
    localparam int     SETTLE_CYCLES = 64;
    localparam int     DRAIN_CYCLES  = 200;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     RANDOM_ITEMS  = 140;
    localparam int     MAX_REPORTS   = 40;

    // Scoreboard: holds its own copy of the sample store, the count and the
    // length register, and turns every closing sample into the burst of
    // points that the block must emit.
    class resample_board;
        t_sample          store [STORE_DEPTH];
        int unsigned      held;
        logic [CFG_W-1:0] length_reg;
        t_out_item        pending_points [$];
        int               errors;
        int               points_checked;
        int               segments_closed;

        function new();
            length_reg      = TARGET_RESET;
            held            = 0;
            errors          = 0;
            points_checked  = 0;
            segments_closed = 0;
        endfunction

        function void set_length(logic [CFG_W-1:0] v);
            length_reg = v;
        endfunction

        function t_out_item make_point(longint v, bit last_flag);
            t_out_item p;
            if (v > VALUE_HI) v = VALUE_HI;
            if (v < VALUE_LO) v = VALUE_LO;
            p.value      = v[VALUE_W-1:0];
            p.last_point = last_flag;
            return p;
        endfunction

        // Appends one predicted point at the tail of the expected queue.
        function void add_point(longint v, bit last_flag);
            pending_points.insert(pending_points.size(), make_point(v, last_flag));
        endfunction

        function void note_sample(t_in_item it);
            int unsigned len, n, segs, base, rem, pts, emitted, j, k;
            longint      pre, cur, slope;
            if (held < STORE_DEPTH) begin
                store[held] = it.sample;
                held++;
            end
            if (!it.segment_end) return;
            segments_closed++;
            len  = (length_reg > MAX_POINTS_DEF) ? MAX_POINTS_DEF : length_reg;
            n    = (held > len + 1) ? len + 1 : held;
            held = 0;
            if (len == 0) return;
            if (n <= 1) begin
                // A lone sample is simply repeated over the whole burst.
                for (k = 0; k < len; k++)
                    add_point(longint'(store[0]) * SCALE, k + 1 == len);
                return;
            end
            segs    = n - 1;
            base    = len / segs;
            rem     = len - base * segs;
            emitted = 0;
            for (j = 1; j < n && emitted < len; j++) begin
                pts = base + ((j <= rem) ? 1 : 0);
                if (pts == 0) continue;
                pre   = store[j-1];
                cur   = store[j];
                slope = ((cur - pre) * SCALE) / longint'(pts);
                for (k = 0; k < pts && emitted < len; k++) begin
                    add_point(pre * SCALE + slope * k, emitted + 1 == len);
                    emitted++;
                end
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("MISMATCH: %s", what);
        endtask

        task check_point(t_out_item got);
            t_out_item want;
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected point value=%0d last=%0b",
                                 got.value, got.last_point));
                return;
            end
            want = pending_points.pop_front();
            points_checked++;
            if (got.value !== want.value)
                report($sformatf("point %0d value got %0d want %0d",
                                 points_checked, got.value, want.value));
            if (got.last_point !== want.last_point)
                report($sformatf("point %0d last flag got %0b want %0b",
                                 points_checked, got.last_point, want.last_point));
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_item         i_item;
    logic             o_result_valid;
    t_out_item        o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    resample_board board;
    bit            no_gaps;
    int            samples_sent;
    int            random_items;
    int            length_writes;

    segment_linear_resampler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Observe every handshake at the edge that completes it. Inputs change
    // only through nonblocking assignments, so the values seen here are the
    // ones the block samples at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) board.check_point(o_result);
            if (i_cfg_valid && o_cfg_ready) board.set_length(i_cfg_data);
            if (start && !busy) board.note_sample(i_item);
        end
    end

    // Watchdog: the run is declared hung when no request, result or register
    // write has moved for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Timeout: no activity for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Hands one sample request to the block. The sender idles for a random
    // number of cycles first, unless the current stretch runs without gaps.
    // Start is only lowered when a gap follows, so back-to-back requests
    // never see it dropped and raised within one step.
    task automatic push_sample(t_sample s, logic closing);
        int unsigned gap;
        t_in_item    it;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.sample      = s;
        it.segment_end = closing;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        samples_sent++;
    endtask

    // Waits until the last burst has been checked, then lets the block run
    // out of any work that produces no points (a length of zero, for one).
    task automatic settle();
        start <= 1'b0;
        while (board.pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_length(logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        length_writes++;
    endtask

    // Extremes turn up often so that full-scale slopes are common.
    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_segment(int unsigned count);
        for (int unsigned i = 1; i <= count; i++)
            push_sample(pick_sample(), i == count);
        random_items += count;
    endtask

    initial begin : stimulus
        board         = new();
        no_gaps       = 1'b0;
        samples_sent  = 0;
        random_items  = 0;
        length_writes = 0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first at the reset length of 50 points.
        // A lone sample: the burst repeats it.
        push_sample(16'sh8000, 1'b1);
        // Full-scale fall over one segment.
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b1);
        // Two segments with an even split; alternating bit patterns.
        push_sample(16'sh0000, 1'b0);
        push_sample(16'sh5555, 1'b0);
        push_sample(16'shAAAA, 1'b1);
        settle();

        // Length zero: the segment closes without any point.
        write_length(7'd0);
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd7, 1'b1);
        settle();

        // Largest register value, limited by the block to 64 points.
        write_length(7'd127);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sh7FFF, 1'b1);
        settle();

        // One point only: a long segment collapses to its first two samples.
        write_length(7'd1);
        push_sample(16'sd100, 1'b0);
        push_sample(-16'sd100, 1'b0);
        push_sample(16'sd3, 1'b0);
        push_sample(16'sd4, 1'b1);
        settle();

        // Exactly the maximum number of points over a full-scale rise.
        write_length(7'd64);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b1);
        settle();

        // Just above the maximum, with a lone sample.
        write_length(7'd65);
        push_sample(16'sh7FFF, 1'b1);
        settle();

        // Random part: phases of one to three segments, each phase with a
        // fresh length half of the time and sometimes without sender gaps.
        // Most segments are short; now and then one overruns the store so
        // that the sample count saturates.
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0:       write_length(7'd0);
                    1:       write_length(7'd1);
                    2:       write_length(7'd64);
                    3:       write_length(7'($urandom_range(65, 127)));
                    default: write_length(7'($urandom_range(2, 63)));
                endcase
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                if (random_items < RANDOM_ITEMS) begin
                    if ($urandom_range(0, 11) == 0)
                        send_segment($urandom_range(60, 72));
                    else
                        send_segment($urandom_range(1, 8));
                end
            end
            settle();
        end

        // Drain: nothing should be left, and nothing more should arrive.
        start <= 1'b0;
        while (board.pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending_points.size() != 0)
            board.report($sformatf("%0d points never arrived",
                                   board.pending_points.size()));

        $display("Run covered %0d samples in %0d segments and %0d length writes.",
                 samples_sent, board.segments_closed, length_writes);
        $display("Checked %0d interpolated points, %0d mismatches.",
                 board.points_checked, board.errors);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
